// ===== rtl/timer_event_queue_unit_defines.svh =====
// ----------------------------------------------------------------------------
// timer_event_queue_unit_defines.svh
// Assertion macros for the timer event queue top-level RTL.
// ----------------------------------------------------------------------------
`ifndef TIMER_EVENT_QUEUE_UNIT_DEFINES_SVH
`define TIMER_EVENT_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TEQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer event queue check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define TEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer event queue check failed");

`endif

// ===== rtl/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg
// Types and codes shared by the timer event queue modules.
// ----------------------------------------------------------------------------
package teq_pkg;

  typedef logic [15:0] code_t;
  typedef logic [4:0]  qcnt_t;
  typedef logic [3:0]  tcnt_t;

  // request operation codes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_POST   = 3'd1,
    OP_POP    = 3'd2,
    OP_ADD    = 3'd3,
    OP_CANCEL = 3'd4
  } op_e;

  // request payload
  typedef struct packed {
    logic [2:0] operation;
    code_t      event_code;
    logic       periodic;
    code_t      period;
  } teq_req_t;

  // result payload
  typedef struct packed {
    logic  accepted;
    logic  event_valid;
    code_t popped_code;
    qcnt_t queue_count;
    logic  queue_full;
    tcnt_t timer_count;
  } teq_rsp_t;

  // one timer table entry as stored in memory
  typedef struct packed {
    code_t event_code;
    code_t remaining;
    code_t reload;
    logic  periodic;
  } teq_timer_t;

  // finished request from the sequencer
  typedef struct packed {
    logic     done;
    teq_rsp_t rsp;
  } teq_fin_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_PSCAN,
    ST_WEX,
    ST_WWB,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/teq_ram.sv =====
// ----------------------------------------------------------------------------
// teq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module teq_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/teq_ctrl.sv =====
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer for the event ring and timer table: duplicate scan on post,
// read-modify-write walk of the timer slots on tick and cancel.
// ----------------------------------------------------------------------------
module teq_ctrl #(
  parameter int EVENT_DEPTH = 16,
  parameter int TIMER_SLOTS = 8,
  localparam int QAW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1,
  localparam int TAW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  teq_pkg::teq_req_t   req_i,
  output logic                busy_o,
  output teq_pkg::teq_fin_t   fin_o,
  // event ring memory
  output logic                ring_we_o,
  output logic [QAW-1:0]      ring_waddr_o,
  output teq_pkg::code_t      ring_wdata_o,
  output logic                ring_re_o,
  output logic [QAW-1:0]      ring_raddr_o,
  input  teq_pkg::code_t      ring_rdata_i,
  // timer table memory
  output logic                timer_we_o,
  output logic [TAW-1:0]      timer_waddr_o,
  output teq_pkg::teq_timer_t timer_wdata_o,
  output logic                timer_re_o,
  output logic [TAW-1:0]      timer_raddr_o,
  input  teq_pkg::teq_timer_t timer_rdata_i
);

  localparam int QCW = $clog2(EVENT_DEPTH + 1);
  localparam int TCW = $clog2(TIMER_SLOTS + 1);
  localparam logic [QAW-1:0] QLast  = QAW'(EVENT_DEPTH - 1);
  localparam logic [QCW-1:0] QDepth = QCW'(EVENT_DEPTH);
  localparam logic [TCW-1:0] TSlots = TCW'(TIMER_SLOTS);

  teq_pkg::state_e     state_q, state_d;
  logic [QAW-1:0]      head_q, head_d, tail_q, tail_d, scan_q, scan_d;
  logic                full_q, full_d;
  logic [TCW-1:0]      used_q, used_d, r_q, r_d, w_q, w_d;
  logic [QCW-1:0]      left_q, left_d;
  logic                rd_vld_q, rd_vld_d;
  logic                acc_q, acc_d, vld_q, vld_d, tick_q, tick_d, keep_q, keep_d;
  teq_pkg::code_t      popped_q, popped_d, code_q, code_d;
  teq_pkg::teq_timer_t cur_q, cur_d;

  logic                accept, q_empty, expire, keep_now, adv_keep, advance;
  logic                more, dup, scan_end, add_ok;
  logic [QAW-1:0]      head_nxt, tail_nxt;
  logic [QCW-1:0]      qlen;
  logic [TCW-1:0]      r_nxt, w_adv;
  teq_pkg::code_t      rem_dec;
  teq_pkg::teq_timer_t ent, ent_upd, adv_ent;

  function automatic logic [QAW-1:0] ring_next(input logic [QAW-1:0] p);
    return (p == QLast) ? '0 : p + 1'b1;
  endfunction

  // queue status
  assign accept   = start_i && (state_q == teq_pkg::ST_IDLE);
  assign q_empty  = !full_q && (head_q == tail_q);
  assign head_nxt = ring_next(head_q);
  assign tail_nxt = ring_next(tail_q);

  always_comb begin
    if (full_q) begin
      qlen = QDepth;
    end else if (tail_q >= head_q) begin
      qlen = QCW'(tail_q) - QCW'(head_q);
    end else begin
      qlen = QDepth - QCW'(head_q) + QCW'(tail_q);
    end
  end

  // timer entry update during the slot walk
  assign ent     = timer_rdata_i;
  assign rem_dec = ent.remaining - 16'd1;
  assign expire  = tick_q && (rem_dec == '0);

  always_comb begin
    ent_upd = ent;
    if (tick_q) begin
      ent_upd.remaining = expire ? ent.reload : rem_dec;
    end
  end

  assign keep_now = tick_q ? 1'b1 : (ent.event_code != code_q);
  assign advance  = ((state_q == teq_pkg::ST_WEX) && !expire) || (state_q == teq_pkg::ST_WWB);
  assign adv_ent  = (state_q == teq_pkg::ST_WWB) ? cur_q : ent_upd;
  assign adv_keep = (state_q == teq_pkg::ST_WWB) ? keep_q : keep_now;
  assign r_nxt    = r_q + 1'b1;
  assign more     = r_nxt < used_q;
  assign w_adv    = adv_keep ? w_q + 1'b1 : w_q;

  // duplicate scan and add checks
  assign dup      = rd_vld_q && (ring_rdata_i == code_q);
  assign scan_end = (left_q == '0);
  assign add_ok   = (req_i.period != '0) && (used_q < TSlots);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      teq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_i.operation)
            teq_pkg::OP_TICK, teq_pkg::OP_CANCEL: begin
              state_d = (used_q != '0) ? teq_pkg::ST_WEX : teq_pkg::ST_RESP;
            end
            teq_pkg::OP_POST: state_d = full_q ? teq_pkg::ST_RESP : teq_pkg::ST_PSCAN;
            teq_pkg::OP_POP:  state_d = q_empty ? teq_pkg::ST_RESP : teq_pkg::ST_POP;
            default:          state_d = teq_pkg::ST_RESP;
          endcase
        end
      end
      teq_pkg::ST_WEX: begin
        if (expire) begin
          state_d = full_q ? teq_pkg::ST_WWB : teq_pkg::ST_PSCAN;
        end else begin
          state_d = more ? teq_pkg::ST_WEX : teq_pkg::ST_RESP;
        end
      end
      teq_pkg::ST_WWB: state_d = more ? teq_pkg::ST_WEX : teq_pkg::ST_RESP;
      teq_pkg::ST_PSCAN: begin
        if (dup || scan_end) begin
          state_d = tick_q ? teq_pkg::ST_WWB : teq_pkg::ST_RESP;
        end
      end
      teq_pkg::ST_POP:  state_d = teq_pkg::ST_RESP;
      teq_pkg::ST_RESP: state_d = teq_pkg::ST_IDLE;
      default:          state_d = teq_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory controls and outputs
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    full_d   = full_q;
    used_d   = used_q;
    scan_d   = scan_q;
    left_d   = left_q;
    rd_vld_d = 1'b0;
    r_d      = r_q;
    w_d      = w_q;
    acc_d    = acc_q;
    vld_d    = vld_q;
    popped_d = popped_q;
    code_d   = code_q;
    tick_d   = tick_q;
    cur_d    = cur_q;
    keep_d   = keep_q;

    ring_we_o     = 1'b0;
    ring_waddr_o  = tail_q;
    ring_wdata_o  = code_q;
    ring_re_o     = 1'b0;
    ring_raddr_o  = scan_q;
    timer_we_o    = 1'b0;
    timer_waddr_o = w_q[TAW-1:0];
    timer_wdata_o = adv_ent;
    timer_re_o    = 1'b0;
    timer_raddr_o = r_nxt[TAW-1:0];

    unique case (state_q)
      teq_pkg::ST_IDLE: begin
        if (accept) begin
          acc_d    = 1'b0;
          vld_d    = 1'b0;
          popped_d = '0;
          code_d   = req_i.event_code;
          tick_d   = (req_i.operation == teq_pkg::OP_TICK);
          r_d      = '0;
          w_d      = '0;
          unique case (req_i.operation)
            teq_pkg::OP_TICK, teq_pkg::OP_CANCEL: begin
              if (used_q != '0) begin
                timer_re_o    = 1'b1;
                timer_raddr_o = '0;
              end
            end
            teq_pkg::OP_POST: begin
              scan_d = head_q;
              left_d = qlen;
            end
            teq_pkg::OP_POP: begin
              if (!q_empty) begin
                ring_re_o    = 1'b1;
                ring_raddr_o = head_q;
              end
            end
            teq_pkg::OP_ADD: begin
              if (add_ok) begin
                timer_we_o               = 1'b1;
                timer_waddr_o            = used_q[TAW-1:0];
                timer_wdata_o.event_code = req_i.event_code;
                timer_wdata_o.remaining  = req_i.period;
                timer_wdata_o.reload     = req_i.period;
                timer_wdata_o.periodic   = req_i.periodic;
                used_d                   = used_q + 1'b1;
                acc_d                    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      teq_pkg::ST_WEX: begin
        // expiring timer posts its code, unless the queue is full or holds it, before the slot is written back
        if (expire) begin
          code_d = ent.event_code;
          cur_d  = ent_upd;
          keep_d = ent.periodic;
          scan_d = head_q;
          left_d = qlen;
        end
      end
      teq_pkg::ST_PSCAN: begin
        if (dup) begin
          // same code already queued, drop the post
        end else if (scan_end) begin
          ring_we_o = 1'b1;
          tail_d    = tail_nxt;
          full_d    = (tail_nxt == head_q);
          if (!tick_q) begin
            acc_d = 1'b1;
          end
        end else begin
          ring_re_o = 1'b1;
          scan_d    = ring_next(scan_q);
          left_d    = left_q - 1'b1;
          rd_vld_d  = 1'b1;
        end
      end
      teq_pkg::ST_POP: begin
        popped_d = ring_rdata_i;
        head_d   = head_nxt;
        full_d   = 1'b0;
        acc_d    = 1'b1;
        vld_d    = 1'b1;
      end
      default: ;
    endcase

    // slot walk step: compact kept entries downward, fetch the next slot
    if (advance) begin
      timer_we_o = adv_keep;
      w_d        = w_adv;
      r_d        = r_nxt;
      if (!tick_q && !adv_keep) begin
        acc_d = 1'b1;
      end
      if (more) begin
        timer_re_o = 1'b1;
      end else begin
        used_d = w_adv;
      end
    end

    busy_o                      = (state_q != teq_pkg::ST_IDLE);
    fin_o.done                  = (state_q == teq_pkg::ST_RESP);
    fin_o.rsp.accepted          = acc_q;
    fin_o.rsp.event_valid       = vld_q;
    fin_o.rsp.popped_code       = popped_q;
    fin_o.rsp.queue_count       = teq_pkg::qcnt_t'(qlen);
    fin_o.rsp.queue_full        = full_q;
    fin_o.rsp.timer_count       = teq_pkg::tcnt_t'(used_q);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= teq_pkg::ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      full_q   <= 1'b0;
      used_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      full_q   <= full_d;
      used_q   <= used_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    left_q   <= left_d;
    r_q      <= r_d;
    w_q      <= w_d;
    acc_q    <= acc_d;
    vld_q    <= vld_d;
    popped_q <= popped_d;
    code_q   <= code_d;
    tick_q   <= tick_d;
    cur_q    <= cur_d;
    keep_q   <= keep_d;
  end

endmodule

// ===== rtl/timer_event_queue_unit.sv =====
// ----------------------------------------------------------------------------
// timer_event_queue_unit
// Event code ring queue with a table of one-shot and periodic timers.
//
//   channel   signals                  direction  handshake
//   request   start, req_i, busy       in         start && !busy
//   result    done_o, rsp_o            out        done_o, one cycle, no stall
//
// Add and empty pop need no memory walk, and pop reads one ring entry; post
// scans the queued events, tick and cancel walk the timers in use, and each
// timer that expires posts its code with a scan of the queue. Posts to a full
// queue skip the scan. Request time is set by the one read port of each
// memory: the duplicate scan reads one ring entry a cycle and the slot walk
// reads one timer entry a cycle, paused while an expiring timer posts.
// Reset clears the ring pointers, full flag and timer count; memory contents
// are left as they are and need no clearing pass.
// A new request is taken in the cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
`include "timer_event_queue_unit_defines.svh"

module timer_event_queue_unit #(
  parameter int EVENT_DEPTH = 16,
  parameter int TIMER_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  teq_pkg::teq_req_t req_i,
  output logic              busy,
  output logic              done_o,
  output teq_pkg::teq_rsp_t rsp_o
);

  localparam int QAW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int TAW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam teq_pkg::qcnt_t QFull = teq_pkg::qcnt_t'(EVENT_DEPTH);

  logic                ring_we, ring_re, timer_we, timer_re;
  logic [QAW-1:0]      ring_waddr, ring_raddr;
  logic [TAW-1:0]      timer_waddr, timer_raddr;
  teq_pkg::code_t      ring_wdata, ring_rdata;
  teq_pkg::teq_timer_t timer_wdata, timer_rdata;
  teq_pkg::teq_fin_t   fin;
  logic                done_q;
  teq_pkg::teq_rsp_t   rsp_q;

  // sequencer
  teq_ctrl #(
    .EVENT_DEPTH (EVENT_DEPTH),
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_i         (req_i),
    .busy_o        (busy),
    .fin_o         (fin),
    .ring_we_o     (ring_we),
    .ring_waddr_o  (ring_waddr),
    .ring_wdata_o  (ring_wdata),
    .ring_re_o     (ring_re),
    .ring_raddr_o  (ring_raddr),
    .ring_rdata_i  (ring_rdata),
    .timer_we_o    (timer_we),
    .timer_waddr_o (timer_waddr),
    .timer_wdata_o (timer_wdata),
    .timer_re_o    (timer_re),
    .timer_raddr_o (timer_raddr),
    .timer_rdata_i (timer_rdata)
  );

  // event ring storage
  teq_ram #(
    .Width ($bits(teq_pkg::code_t)),
    .Depth (EVENT_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // timer table storage
  teq_ram #(
    .Width ($bits(teq_pkg::teq_timer_t)),
    .Depth (TIMER_SLOTS)
  ) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (timer_we),
    .waddr_i (timer_waddr),
    .wdata_i (timer_wdata),
    .re_i    (timer_re),
    .raddr_i (timer_raddr),
    .rdata_o (timer_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin.done) begin
      rsp_q <= fin.rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // checks
  `TEQ_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `TEQ_ASSERT_NEXT(a_busy_on_request, start && !busy, busy)
  `TEQ_ASSERT_IMPL(a_done_on_finish, $fell(busy), done_o)
  `TEQ_ASSERT_IMPL(a_full_count, done_o && rsp_o.queue_full, rsp_o.queue_count == QFull)

endmodule

// ===== tb/tb_timer_event_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_timer_event_queue_unit
// Self-checking bench for the timer event queue: requests go in on the
// start/busy handshake with random gaps, and a predictor of the event ring
// and timer table works out the status each request must return. Every
// result strobe is compared field by field against the oldest outstanding
// prediction.
// ----------------------------------------------------------------------------
module tb_timer_event_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 16;
  localparam int SLOT_COUNT  = 8;
  localparam int REQ_TARGET  = 550;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;

  // small code set so duplicates and cancel hits come up often
  localparam teq_pkg::code_t CODE_POOL [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                               16'h00A5, 16'h5A00, 16'h1234, 16'hC3C3};

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  teq_pkg::teq_req_t req_i;
  logic              busy;
  logic              done_o;
  teq_pkg::teq_rsp_t rsp_o;

  timer_event_queue_unit #(
    .EVENT_DEPTH(RING_DEPTH),
    .TIMER_SLOTS(SLOT_COUNT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predicted event ring
  teq_pkg::code_t ring_q [RING_DEPTH];
  int unsigned    ring_head;
  int unsigned    ring_tail;
  bit             ring_full;

  // predicted timer table
  teq_pkg::code_t slot_code   [SLOT_COUNT];
  teq_pkg::code_t slot_left   [SLOT_COUNT];
  teq_pkg::code_t slot_reload [SLOT_COUNT];
  bit             slot_per    [SLOT_COUNT];
  int unsigned    slots_used;

  teq_pkg::teq_rsp_t status_due [$];

  int errors;
  int sent;
  int checked;
  int popped_events;
  int expiries;
  int full_hits;
  int calm_left;
  longint cycle_count;

  function automatic int unsigned ring_len();
    if (ring_full) return RING_DEPTH;
    return (ring_tail + RING_DEPTH - ring_head) % RING_DEPTH;
  endfunction

  // queue a code unless full or already waiting
  function automatic bit ring_post(teq_pkg::code_t c);
    int unsigned i;
    if (ring_full) return 1'b0;
    i = ring_head;
    while (i != ring_tail) begin
      if (ring_q[i] == c) return 1'b0;
      i = (i + 1) % RING_DEPTH;
    end
    ring_q[ring_tail] = c;
    ring_tail = (ring_tail + 1) % RING_DEPTH;
    ring_full = (ring_tail == ring_head);
    return 1'b1;
  endfunction

  function automatic void move_slot(int unsigned to, int unsigned from);
    slot_code[to]   = slot_code[from];
    slot_left[to]   = slot_left[from];
    slot_reload[to] = slot_reload[from];
    slot_per[to]    = slot_per[from];
  endfunction

  // status after one request, updating the predicted ring and table
  function automatic teq_pkg::teq_rsp_t advance_queue_and_timers(teq_pkg::teq_req_t r);
    teq_pkg::teq_rsp_t s;
    int unsigned       w;
    bit                keep;
    s = '0;
    case (teq_pkg::op_e'(r.operation))
      teq_pkg::OP_TICK: begin
        w = 0;
        for (int unsigned k = 0; k < slots_used; k++) begin
          keep = 1'b1;
          slot_left[k] = slot_left[k] - 16'd1;
          if (slot_left[k] == 16'd0) begin
            expiries++;
            void'(ring_post(slot_code[k]));
            if (slot_per[k]) slot_left[k] = slot_reload[k];
            else keep = 1'b0;
          end
          if (keep) begin
            if (w != k) move_slot(w, k);
            w++;
          end
        end
        slots_used = w;
      end
      teq_pkg::OP_POST: begin
        s.accepted = ring_post(r.event_code);
      end
      teq_pkg::OP_POP: begin
        if (ring_head != ring_tail || ring_full) begin
          s.popped_code = ring_q[ring_head];
          ring_head     = (ring_head + 1) % RING_DEPTH;
          ring_full     = 1'b0;
          s.accepted    = 1'b1;
          s.event_valid = 1'b1;
        end
      end
      teq_pkg::OP_ADD: begin
        if (r.period != 16'd0 && slots_used < SLOT_COUNT) begin
          slot_code[slots_used]   = r.event_code;
          slot_left[slots_used]   = r.period;
          slot_reload[slots_used] = r.period;
          slot_per[slots_used]    = r.periodic;
          slots_used++;
          s.accepted = 1'b1;
        end
      end
      teq_pkg::OP_CANCEL: begin
        w = 0;
        for (int unsigned k = 0; k < slots_used; k++) begin
          if (slot_code[k] == r.event_code) begin
            s.accepted = 1'b1;
          end else begin
            if (w != k) move_slot(w, k);
            w++;
          end
        end
        slots_used = w;
      end
      default: ;
    endcase
    s.queue_count = teq_pkg::qcnt_t'(ring_len());
    s.queue_full  = ring_full;
    s.timer_count = teq_pkg::tcnt_t'(slots_used);
    return s;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result checking and prediction, both on the rising edge
  always @(posedge clk_i) begin : scoreboard
    teq_pkg::teq_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (status_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, rsp_o);
        end else begin
          want = status_due.pop_front();
          checked++;
          if (want.event_valid) popped_events++;
          if (want.queue_full) full_hits++;
          compare_field("accepted", 16'(want.accepted), 16'(rsp_o.accepted));
          compare_field("event_valid", 16'(want.event_valid), 16'(rsp_o.event_valid));
          compare_field("popped_code", want.popped_code, rsp_o.popped_code);
          compare_field("queue_count", 16'(want.queue_count), 16'(rsp_o.queue_count));
          compare_field("queue_full", 16'(want.queue_full), 16'(rsp_o.queue_full));
          compare_field("timer_count", 16'(want.timer_count), 16'(rsp_o.timer_count));
        end
      end
      if (start && !busy) status_due.push_back(advance_queue_and_timers(req_i));
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("tb_timer_event_queue_unit: errors");
      $finish;
    end
  end

  // idle cycles before a request: mostly none, some short, a few long
  function automatic int pick_gap();
    int x;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    x = $urandom_range(0, 99);
    if (x < 5) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (x < 50) return 0;
    if (x < 85) return $urandom_range(1, 3);
    if (x < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic teq_pkg::code_t pick_code();
    if ($urandom_range(0, 3) != 0) return CODE_POOL[$urandom_range(0, 7)];
    return teq_pkg::code_t'($urandom);
  endfunction

  // mostly short periods so timers expire within a few ticks
  function automatic teq_pkg::code_t pick_period();
    int x;
    x = $urandom_range(0, 99);
    if (x < 70) return teq_pkg::code_t'($urandom_range(1, 4));
    if (x < 90) return teq_pkg::code_t'($urandom_range(5, 20));
    if (x < 97) return teq_pkg::code_t'($urandom_range(1, 65535));
    return 16'hFFFF;
  endfunction

  // one request; called and returns at a falling edge
  task automatic send_req(input teq_pkg::teq_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // fields the operation does not use carry random values
  task automatic send_op(input teq_pkg::op_e op, input teq_pkg::code_t c, input bit per,
                         input teq_pkg::code_t period);
    teq_pkg::teq_req_t r;
    r.operation  = op;
    r.event_code = c;
    r.periodic   = per;
    r.period     = period;
    if (op != teq_pkg::OP_ADD) begin
      r.periodic = 1'($urandom_range(0, 1));
      r.period   = teq_pkg::code_t'($urandom);
    end
    if (op == teq_pkg::OP_TICK || op == teq_pkg::OP_POP) begin
      r.event_code = teq_pkg::code_t'($urandom);
    end
    send_req(r);
  endtask

  task automatic drain_queue();
    while (ring_len() > 0) send_op(teq_pkg::OP_POP, '0, 1'b0, '0);
    send_op(teq_pkg::OP_POP, '0, 1'b0, '0);
  endtask

  task automatic flush_timers();
    foreach (CODE_POOL[i]) send_op(teq_pkg::OP_CANCEL, CODE_POOL[i], 1'b0, '0);
  endtask

  // empty pops, rejects, field extremes, adjacent expiries and reloads
  task automatic test_special_cases();
    send_op(teq_pkg::OP_POP, '0, 1'b0, '0);
    send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
    send_op(teq_pkg::OP_CANCEL, 16'h0000, 1'b0, '0);
    send_op(teq_pkg::OP_ADD, 16'hFFFF, 1'b1, 16'h0000);
    send_op(teq_pkg::OP_POST, 16'h0000, 1'b0, '0);
    send_op(teq_pkg::OP_POST, 16'h0000, 1'b0, '0);
    send_op(teq_pkg::OP_POST, 16'hFFFF, 1'b0, '0);
    send_op(teq_pkg::OP_POP, '0, 1'b0, '0);
    send_op(teq_pkg::OP_ADD, 16'hFFFF, 1'b0, 16'd1);
    send_op(teq_pkg::OP_ADD, 16'hFFFF, 1'b0, 16'd1);
    send_op(teq_pkg::OP_ADD, 16'h0000, 1'b1, 16'd2);
    send_op(teq_pkg::OP_ADD, 16'h8001, 1'b1, 16'hFFFF);
    send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
    send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
    send_op(teq_pkg::OP_CANCEL, 16'h8001, 1'b0, '0);
    send_op(teq_pkg::OP_ADD, 16'h5A5A, 1'b0, 16'd1);
    send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
    send_op(teq_pkg::OP_CANCEL, 16'h0000, 1'b0, '0);
    drain_queue();
  endtask

  // fill to full, overflow and duplicate rejects, pop clears full
  task automatic test_queue_limits();
    teq_pkg::code_t first;
    drain_queue();
    first = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      send_op(teq_pkg::OP_POST, {12'($urandom), 4'(i)}, 1'b0, '0);
      if (i == 0) first = ring_q[ring_head];
    end
    send_op(teq_pkg::OP_POST, teq_pkg::code_t'($urandom), 1'b0, '0);
    send_op(teq_pkg::OP_POST, ring_q[(ring_head + 5) % RING_DEPTH], 1'b0, '0);
    send_op(teq_pkg::OP_POP, '0, 1'b0, '0);
    send_op(teq_pkg::OP_POST, ring_q[(ring_head + 3) % RING_DEPTH], 1'b0, '0);
    send_op(teq_pkg::OP_POST, first, 1'b0, '0);
    send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
    drain_queue();
  endtask

  // full table, reject past full, cancel of adjacent matching slots
  task automatic test_timer_table_limits();
    teq_pkg::code_t codes [9];
    codes = '{CODE_POOL[2], CODE_POOL[2], CODE_POOL[4], CODE_POOL[2],
              CODE_POOL[2], CODE_POOL[4], CODE_POOL[2], CODE_POOL[2],
              CODE_POOL[4]};
    flush_timers();
    foreach (codes[i])
      send_op(teq_pkg::OP_ADD, codes[i], 1'($urandom_range(0, 1)),
              teq_pkg::code_t'($urandom_range(2, 6)));
    send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
    send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
    send_op(teq_pkg::OP_CANCEL, CODE_POOL[2], 1'b0, '0);
    send_op(teq_pkg::OP_CANCEL, CODE_POOL[4], 1'b0, '0);
    send_op(teq_pkg::OP_CANCEL, CODE_POOL[4], 1'b0, '0);
    send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
    drain_queue();
  endtask

  // mixed bursts of posts, timer churn, drains and scattered requests
  task automatic test_random_traffic();
    int x;
    int n;
    while (sent < REQ_TARGET) begin
      case ($urandom_range(0, 11))
        0: begin
          while (!ring_full) begin
            send_op(teq_pkg::OP_POST, pick_code() ^ teq_pkg::code_t'($urandom),
                    1'b0, '0);
          end
          repeat ($urandom_range(1, 3)) send_op(teq_pkg::OP_POST, pick_code(), 1'b0, '0);
        end
        1, 2, 3: begin
          n = $urandom_range(1, 4);
          repeat (n) send_op(teq_pkg::OP_ADD, CODE_POOL[$urandom_range(0, 7)],
                             1'($urandom_range(0, 1)), pick_period());
          repeat ($urandom_range(1, 6)) send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
        end
        4: drain_queue();
        5: if ($urandom_range(0, 2) == 0) flush_timers();
        default: begin
          x = $urandom_range(0, 99);
          if (x < 30) send_op(teq_pkg::OP_TICK, '0, 1'b0, '0);
          else if (x < 55) send_op(teq_pkg::OP_POST, pick_code(), 1'b0, '0);
          else if (x < 75) send_op(teq_pkg::OP_POP, '0, 1'b0, '0);
          else if (x < 88)
            send_op(teq_pkg::OP_ADD, CODE_POOL[$urandom_range(0, 7)],
                    1'($urandom_range(0, 1)),
                    ($urandom_range(0, 19) == 0) ? 16'h0000 : pick_period());
          else send_op(teq_pkg::OP_CANCEL, pick_code(), 1'b0, '0);
        end
      endcase
    end
  endtask

  // reset, tests in turn, then wait out the last results
  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_special_cases();
    test_queue_limits();
    test_timer_table_limits();
    test_random_traffic();

    start <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d checked results: %0d events popped,",
             sent, checked, popped_events);
    $display("  %0d timer expiries, %0d results with the queue full", expiries,
             full_hits);
    if (errors == 0 && status_due.size() == 0) begin
      $display("tb_timer_event_queue_unit: clean");
    end else begin
      $display("tb_timer_event_queue_unit: errors");
    end
    $finish;
  end

endmodule
